FILE: rtl/core/aktss_pkg.sv
// Package for the ASCII/key-event scancode sequencer.
// Holds the sequence descriptor types, scancode constants and the character table.
// No dependencies; every other file in rtl/core except aktss_if refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package aktss_pkg;

  // Input item selector codes.
  localparam logic [1:0] OP_ASCII   = 2'd0;
  localparam logic [1:0] OP_KEY     = 2'd1;
  localparam logic [1:0] OP_COMMAND = 2'd2;

  // Host command codes.
  localparam logic [7:0] CMD_RESET = 8'h01;
  localparam logic [7:0] CMD_ABORT = 8'h03;

  // Scancodes and response bytes.
  localparam logic [6:0] SC_LSHIFT   = 7'd99;
  localparam logic [6:0] SC_RSHIFT   = 7'd111;
  localparam logic [6:0] SC_CTRL     = 7'd76;
  localparam logic [6:0] SC_CAPSLOCK = 7'd119;
  localparam logic [6:0] SC_ABORT    = 7'd77;
  localparam logic [7:0] BREAK_BIT   = 8'h80;
  localparam logic [7:0] RESP_RESET  = 8'hff;
  localparam logic [7:0] RESP_KBD_ID = 8'h02;
  localparam logic [7:0] RESP_IDLE   = 8'h7f;
  localparam logic [7:0] RESP_ONE    = 8'h01;

  // Bit 7 of a table entry marks a character that needs left shift.
  localparam logic [7:0] SH = 8'h80;

  localparam logic [7:0] CHAR_TABLE [128] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd43, 8'd53, 8'd89, 8'd0, 8'd0, 8'd89, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd29, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd121, SH | 8'd30, SH | 8'd87, SH | 8'd32,
    SH | 8'd33, SH | 8'd34, SH | 8'd36, 8'd87,
    SH | 8'd38, SH | 8'd39, SH | 8'd37, SH | 8'd41,
    8'd107, 8'd40, 8'd108, 8'd109,
    8'd39, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36,
    8'd37, 8'd38, SH | 8'd86, 8'd86, SH | 8'd107, 8'd41, SH | 8'd108, SH | 8'd109,
    SH | 8'd31, SH | 8'd77, SH | 8'd104, SH | 8'd102,
    SH | 8'd79, SH | 8'd56, SH | 8'd80, SH | 8'd81,
    SH | 8'd82, SH | 8'd61, SH | 8'd83, SH | 8'd84,
    SH | 8'd85, SH | 8'd106, SH | 8'd105, SH | 8'd62,
    SH | 8'd63, SH | 8'd54, SH | 8'd57, SH | 8'd78,
    SH | 8'd58, SH | 8'd60, SH | 8'd103, SH | 8'd55,
    SH | 8'd101, SH | 8'd59, SH | 8'd100, 8'd64,
    8'd88, 8'd65, SH | 8'd35, SH | 8'd40,
    8'd42, 8'd77, 8'd104, 8'd102, 8'd79, 8'd56, 8'd80, 8'd81,
    8'd82, 8'd61, 8'd83, 8'd84, 8'd85, 8'd106, 8'd105, 8'd62,
    8'd63, 8'd54, 8'd57, 8'd78, 8'd58, 8'd60, 8'd103, 8'd55,
    8'd101, 8'd59, 8'd100, SH | 8'd64, SH | 8'd88, SH | 8'd65, SH | 8'd42, 8'd0
  };

  // Kind of byte burst that one input item asks for.
  typedef enum logic [2:0] {
    KIND_SHIFTED = 3'd0,
    KIND_PLAIN   = 3'd1,
    KIND_SINGLE  = 3'd2,
    KIND_RESET   = 3'd3,
    KIND_ABORT   = 3'd4
  } kind_e;

  // One queued burst: its kind and the scancode (or full byte for a single).
  typedef struct packed {
    kind_e      kind;
    logic [7:0] code;
  } desc_t;

  function automatic logic [2:0] seq_len(kind_e kind);
    logic [2:0] n;
    n = 3'd1;
    case (kind)
      KIND_SHIFTED: n = 3'd4;
      KIND_PLAIN:   n = 3'd2;
      KIND_SINGLE:  n = 3'd1;
      KIND_RESET:   n = 3'd3;
      KIND_ABORT:   n = 3'd5;
      default:      n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] seq_byte(desc_t desc, logic [2:0] idx);
    logic [7:0] b;
    b = '0;
    case (desc.kind)
      KIND_SHIFTED: begin
        case (idx)
          3'd0:    b = {1'b0, SC_LSHIFT};
          3'd1:    b = desc.code;
          3'd2:    b = desc.code | BREAK_BIT;
          default: b = {1'b0, SC_LSHIFT} | BREAK_BIT;
        endcase
      end
      KIND_PLAIN: begin
        b = (idx == 3'd0) ? desc.code : (desc.code | BREAK_BIT);
      end
      KIND_SINGLE: begin
        b = desc.code;
      end
      KIND_RESET: begin
        case (idx)
          3'd0:    b = RESP_RESET;
          3'd1:    b = RESP_KBD_ID;
          default: b = RESP_IDLE;
        endcase
      end
      KIND_ABORT: begin
        case (idx)
          3'd0:    b = RESP_ONE;
          3'd1:    b = {1'b0, SC_ABORT};
          3'd2:    b = {1'b0, SC_ABORT} | BREAK_BIT;
          3'd3:    b = RESP_ONE | BREAK_BIT;
          default: b = RESP_IDLE;
        endcase
      end
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/aktss_if.sv
// Valid/ready channel interfaces for the scancode sequencer.
// aktss_in_if carries input items, aktss_out_if carries code bytes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface aktss_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] ascii_char;
  logic [6:0] key_code;
  logic       key_down;
  logic [7:0] command;

  modport source (output valid, op, ascii_char, key_code, key_down, command,
                  input ready);
  modport sink   (input valid, op, ascii_char, key_code, key_down, command,
                  output ready);
endinterface

interface aktss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last;

  modport source (output valid, code_byte, last, input ready);
  modport sink   (input valid, code_byte, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/aktss_front.sv
// Front end: accepts input beats and turns each into a burst descriptor.
// Depends on aktss_pkg and aktss_in_if.
`timescale 1ns / 1ps
`default_nettype none

module aktss_front (
  aktss_in_if.sink        in_i,
  input  wire logic       q_full_i,
  output aktss_pkg::desc_t desc_o,
  output logic            push_o
);

  aktss_pkg::desc_t desc;
  logic             has_seq;
  logic [7:0]       entry;
  logic             is_mod;

  assign entry  = aktss_pkg::CHAR_TABLE[in_i.ascii_char[6:0]];
  assign is_mod = (in_i.key_code == aktss_pkg::SC_LSHIFT) ||
                  (in_i.key_code == aktss_pkg::SC_RSHIFT) ||
                  (in_i.key_code == aktss_pkg::SC_CTRL) ||
                  (in_i.key_code == aktss_pkg::SC_CAPSLOCK);

  always_comb begin
    has_seq   = 1'b0;
    desc.kind = aktss_pkg::KIND_PLAIN;
    desc.code = '0;
    case (in_i.op)
      aktss_pkg::OP_ASCII: begin
        desc.code = {1'b0, entry[6:0]};
        desc.kind = entry[7] ? aktss_pkg::KIND_SHIFTED : aktss_pkg::KIND_PLAIN;
        has_seq   = !in_i.ascii_char[7] && (entry[6:0] != 7'd0);
      end
      aktss_pkg::OP_KEY: begin
        // Modifiers report both edges; other keys type make and break on press.
        if (is_mod) begin
          desc.kind = aktss_pkg::KIND_SINGLE;
          desc.code = {!in_i.key_down, in_i.key_code};
          has_seq   = 1'b1;
        end else begin
          desc.kind = aktss_pkg::KIND_PLAIN;
          desc.code = {1'b0, in_i.key_code};
          has_seq   = in_i.key_down && (in_i.key_code != 7'd0);
        end
      end
      aktss_pkg::OP_COMMAND: begin
        if (in_i.command == aktss_pkg::CMD_RESET) begin
          desc.kind = aktss_pkg::KIND_RESET;
          has_seq   = 1'b1;
        end else if (in_i.command == aktss_pkg::CMD_ABORT) begin
          desc.kind = aktss_pkg::KIND_ABORT;
          has_seq   = 1'b1;
        end
      end
      default: has_seq = 1'b0;
    endcase
  end

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i && has_seq;
  assign desc_o     = desc;

endmodule

`default_nettype wire

FILE: rtl/core/aktss_queue.sv
// Small descriptor queue between the front and back ends.
// Depends on aktss_pkg for the descriptor type.
`timescale 1ns / 1ps
`default_nettype none

module aktss_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire aktss_pkg::desc_t desc_i,
  output logic                  full_o,
  output logic                  head_valid_o,
  output aktss_pkg::desc_t      head_o,
  input  wire logic             pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  aktss_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue popped while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/core/aktss_back.sv
// Back end: expands burst descriptors into code bytes, one per cycle while the sink is ready.
// Depends on aktss_pkg and aktss_out_if; the output register decouples the sink.
`timescale 1ns / 1ps
`default_nettype none

module aktss_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             head_valid_i,
  input  wire aktss_pkg::desc_t head_i,
  output logic                  pop_o,
  aktss_out_if.source           out_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_BURST = 2'b10
  } state_e;

  state_e           state_q, state_d;
  aktss_pkg::desc_t cur_q, cur_d;
  logic [2:0]       idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       code_q, code_d;
  logic             last_q, last_d;
  logic             adv;
  logic [2:0]       head_len;
  logic [2:0]       cur_len;

  assign adv      = !out_valid_q || out_o.ready;
  assign head_len = aktss_pkg::seq_len(head_i.kind);
  assign cur_len  = aktss_pkg::seq_len(cur_q.kind);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    code_d      = code_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // The first beat of a burst comes straight from the queue head.
        if (adv && head_valid_i) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          code_d      = aktss_pkg::seq_byte(head_i, 3'd0);
          last_d      = (head_len == 3'd1);
          cur_d       = head_i;
          idx_d       = 3'd1;
          if (head_len != 3'd1) begin
            state_d = ST_BURST;
          end
        end
      end
      ST_BURST: begin
        if (adv) begin
          out_valid_d = 1'b1;
          code_d      = aktss_pkg::seq_byte(cur_q, idx_q);
          last_d      = (idx_q == cur_len - 3'd1);
          idx_d       = idx_q + 3'd1;
          if (idx_q == cur_len - 3'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    code_q <= code_d;
    last_q <= last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.code_byte = code_q;
  assign out_o.last      = last_q;

  a_burst_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BURST) |-> (idx_q != 3'd0) && (idx_q < cur_len))
    else $error("burst index outside its sequence");

  a_burst_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (head_len != 3'd1)) |=> (state_q == ST_BURST))
    else $error("multi-byte burst did not enter burst state");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE))
    else $error("descriptor taken in the middle of a burst");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BURST && adv && idx_q == cur_len - 3'd1) |=>
      (out_valid_q && last_q && state_q == ST_IDLE))
    else $error("final beat of a burst not flagged as last");

endmodule

`default_nettype wire

FILE: rtl/core/ascii_key_to_scancode_sequencer_unit.sv
// Top level of the ASCII/key-event to scancode sequencer.
// Depends on aktss_pkg, aktss_if, aktss_front, aktss_queue and aktss_back.
//
// Each input beat (ASCII character, key event or keyboard command) is classified
// by the front end in the cycle it is accepted and, if it produces any bytes, is
// pushed as one descriptor into a QueueDepth-entry queue; beats that produce
// nothing are accepted and dropped. The back end expands descriptors into code
// bytes through an output register at one byte per cycle while the sink is ready.
// An item produces 1 to 5 bytes, and bursts follow one another without gaps while
// the sink is ready. A first byte passes through the queue and the output register. Input
// ready is low only while the queue is full; the output byte rate of the back end
// is what sets the sustained throughput.
`timescale 1ns / 1ps
`default_nettype none

module ascii_key_to_scancode_sequencer_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  aktss_in_if.sink     in_i,
  aktss_out_if.source  out_o
);

  aktss_pkg::desc_t push_desc;
  aktss_pkg::desc_t head_desc;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             head_valid;

  aktss_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .desc_o   (push_desc),
    .push_o   (push)
  );

  aktss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .desc_i       (push_desc),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head_desc),
    .pop_i        (pop)
  );

  aktss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_desc),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
